@@ hw/rtl/chst_pkg.sv @@
package chst_pkg;

    localparam int COORD_W = 32;
    localparam int MUL_AW  = 41;
    localparam int MUL_BW  = 36;
    localparam int MUL_CW  = 18;
    localparam int MUL_PW  = MUL_AW + MUL_BW;

    localparam logic [3:0] OP_CLEAR    = 4'd0;
    localparam logic [3:0] OP_APPEND   = 4'd1;
    localparam logic [3:0] OP_INSERT   = 4'd2;
    localparam logic [3:0] OP_REMOVE   = 4'd3;
    localparam logic [3:0] OP_SET_PT   = 4'd4;
    localparam logic [3:0] OP_SET_POS  = 4'd5;
    localparam logic [3:0] OP_SET_VEL  = 4'd6;
    localparam logic [3:0] OP_CARDINAL = 4'd7;
    localparam logic [3:0] OP_READ     = 4'd8;
    localparam logic [3:0] OP_EVAL_CUM = 4'd9;
    localparam logic [3:0] OP_EVAL_NRM = 4'd10;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_INDEX = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_TOO_FEW   = 2'd3;

    localparam logic [2:0] CFG_TENSION = 3'd0;
    localparam logic [2:0] CFG_START_X = 3'd1;
    localparam logic [2:0] CFG_START_Y = 3'd2;
    localparam logic [2:0] CFG_END_X   = 3'd3;
    localparam logic [2:0] CFG_END_Y   = 3'd4;

    localparam logic [MUL_PW-1:0] PROD_LIMIT = MUL_PW'(1) << 60;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DISPATCH,
        S_SH_UP_RD,
        S_SH_UP_WR,
        S_INS_WR,
        S_SH_DN_RD,
        S_SH_DN_WR,
        S_READ_WAIT,
        S_CA_RD0,
        S_CA_RD1,
        S_CA_DX,
        S_CA_DY,
        S_CA_WR,
        S_CA_END,
        S_EV_SEG,
        S_EV_RD1,
        S_EV_T2,
        S_EV_T3,
        S_EV_AX,
        S_EV_M1,
        S_EV_M2,
        S_EV_M3,
        S_EV_FIN,
        S_MUL0,
        S_MUL1,
        S_DONE
    } state_t;

    function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [63:0] v);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = (64'sd1 <<< (COORD_W - 1)) - 64'sd1;
        lo = -hi - 64'sd1;
        if (v > hi)
        begin
            sat_coord = hi[COORD_W-1:0];
        end
        else if (v < lo)
        begin
            sat_coord = lo[COORD_W-1:0];
        end
        else
        begin
            sat_coord = v[COORD_W-1:0];
        end
    endfunction

endpackage

@@ hw/rtl/cubic_hermite_spline_table_top.sv @@
// Per item: clear, set, unknown and rejected opcodes go straight to the result; read waits
// for the memory read; append, insert and remove shift the moved entries one at a time;
// cardinal visits each interior point; evaluation runs the segment lookup and products.
// Flow: one item at a time, held while a result waits; the one-read, one-write point
// memories and the shared 41x18 multiplier (two passes per product) set the pace.
// Reset: point count and control registers cleared; datapath registers and point memory undefined until written.
module cubic_hermite_spline_table_top
    import chst_pkg::*;
#(
    parameter int MAX_POINTS = 256
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // opcode, index, pos_x, pos_y, vel_x, vel_y, curve_param, zero pad
    input  logic [167:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // out_x, out_y, out_vx, out_vy, point_count, status, zero pad
    output logic [143:0] m_axis_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int XW = 20;

    state_t state_reg, state_next, ret_reg;

    logic [17:0] tension_reg;
    logic [31:0] start_x_reg, start_y_reg, end_x_reg, end_y_reg;

    logic [3:0]  op_reg;
    logic [7:0]  idx_reg;
    logic [31:0] px_reg, py_reg, vx_reg, vy_reg;
    logic [23:0] tp_reg;

    logic [CW-1:0] count_reg, ptr_reg, ins_reg;
    logic [1:0]  status_reg;
    logic [31:0] res_x_reg, res_y_reg, res_vx_reg, res_vy_reg;

    logic [MUL_AW-1:0] mul_a_reg;
    logic [MUL_BW-1:0] mul_b_reg;
    logic              mul_neg_reg;
    logic [MUL_PW-1:0] mul_acc_reg;

    logic [AW-1:0] seg_reg;
    logic [23:0]   tl_reg;
    logic [32:0]   t2_reg;
    logic [40:0]   t3_reg;
    logic [63:0]   p0_reg, v0_reg, pm_reg;
    logic signed [35:0] c_reg, e_reg;
    logic signed [63:0] acc_reg;
    logic          axis_reg;
    logic [31:0]   vnx_reg;

    logic          out_valid_reg;
    logic [31:0]   out_x_reg, out_y_reg, out_vx_reg, out_vy_reg;
    logic [8:0]    out_cnt_reg;
    logic [1:0]    out_st_reg;

    logic [63:0] pos_mem [MAX_POINTS];
    logic [63:0] vel_mem [MAX_POINTS];
    logic [63:0] pos_rd_reg, vel_rd_reg;

    logic          pos_re, vel_re, pos_we, vel_we;
    logic [AW-1:0] rd_addr, wr_addr;
    logic [63:0]   pos_wd, vel_wd;

    // ---------------------------------------------------------------- decode
    logic [15:0] n16, idx16;
    logic        idx_lt_n, idx_le_n, is_full, load_out;

    assign n16      = 16'(count_reg);
    assign idx16    = 16'(idx_reg);
    assign idx_lt_n = idx16 < n16;
    assign idx_le_n = idx16 <= n16;
    assign is_full  = n16 >= 16'(MAX_POINTS);
    assign load_out = (state_reg == S_DONE) && (!out_valid_reg || m_axis_tready);

    // ---------------------------------------------------------------- multiplier
    logic [MUL_CW+MUL_AW-1:0] mul_part;
    logic [MUL_CW-1:0]        mul_chunk;
    logic [MUL_PW-1:0]        mul_rnd;
    logic [60:0]              mul_sat;
    logic signed [63:0]       mul_s;

    assign mul_chunk = (state_reg == S_MUL0) ? mul_b_reg[MUL_CW-1:0]
                                             : mul_b_reg[MUL_BW-1:MUL_CW];
    assign mul_part  = mul_a_reg * mul_chunk;
    assign mul_rnd   = mul_acc_reg + MUL_PW'(32768);
    assign mul_sat   = (mul_acc_reg > PROD_LIMIT) ? PROD_LIMIT[60:0] : mul_acc_reg[60:0];
    assign mul_s     = mul_neg_reg ? -$signed({3'b000, mul_sat}) : $signed({3'b000, mul_sat});

    // ---------------------------------------------------------------- cardinal
    logic signed [XW-1:0] scale;
    logic [XW-1:0]        scale_mag;
    logic signed [32:0]   card_d;
    logic [32:0]          card_d_mag;
    logic signed [31:0]   card_v;

    assign scale     = XW'(65536) - XW'($signed(tension_reg));
    assign scale_mag = scale[XW-1] ? XW'(-scale) : XW'(scale);
    assign card_d    = (state_reg == S_CA_DX)
                       ? $signed({pos_rd_reg[31], pos_rd_reg[31:0]})
                         - $signed({pm_reg[31], pm_reg[31:0]})
                       : $signed({pos_rd_reg[63], pos_rd_reg[63:32]})
                         - $signed({pm_reg[63], pm_reg[63:32]});
    assign card_d_mag = card_d[32] ? 33'(-card_d) : 33'(card_d);
    assign card_v     = sat_coord((mul_s + 64'sd65536) >>> 17);

    // ---------------------------------------------------------------- segment
    logic [32:0] cum;
    logic [16:0] seg_raw, seg_max, seg_c;
    logic [33:0] tl_full;
    logic [23:0] tl_c;

    assign cum     = mul_acc_reg[32:0];
    assign seg_raw = cum[32:16];
    assign seg_max = 17'(count_reg) - 17'd2;
    assign seg_c   = (seg_raw > seg_max) ? seg_max : seg_raw;
    assign tl_full = {1'b0, cum} - {1'b0, seg_c, 16'd0};
    assign tl_c    = (tl_full > 34'hFFFFFF) ? 24'hFFFFFF : tl_full[23:0];

    // ---------------------------------------------------------------- hermite axis
    logic signed [31:0] p0a, p1a, v0a, v1a;
    logic signed [35:0] d36, v036, v136, c_c, e_c;
    logic [35:0]        v0_mag, c_mag, e_mag;
    logic signed [31:0] ev_r;

    assign p0a  = axis_reg ? p0_reg[63:32] : p0_reg[31:0];
    assign v0a  = axis_reg ? v0_reg[63:32] : v0_reg[31:0];
    assign p1a  = axis_reg ? pos_rd_reg[63:32] : pos_rd_reg[31:0];
    assign v1a  = axis_reg ? vel_rd_reg[63:32] : vel_rd_reg[31:0];
    assign d36  = 36'(p1a) - 36'(p0a);
    assign v036 = 36'(v0a);
    assign v136 = 36'(v1a);
    assign c_c  = 36'(d36 * 36'sd3) - (v036 <<< 1) - v136;
    assign e_c  = v036 + v136 - (d36 <<< 1);
    assign v0_mag = v036[35] ? 36'(-v036) : 36'(v036);
    assign c_mag  = c_reg[35] ? 36'(-c_reg) : 36'(c_reg);
    assign e_mag  = e_reg[35] ? 36'(-e_reg) : 36'(e_reg);
    assign ev_r   = sat_coord((acc_reg + 64'sd32768) >>> 16);

    // ---------------------------------------------------------------- next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                state_next = S_DONE;
                case (op_reg)
                    OP_APPEND:
                    begin
                        if (!is_full)
                        begin
                            state_next = S_SH_UP_RD;
                        end
                    end
                    OP_INSERT:
                    begin
                        if (idx_le_n && !is_full)
                        begin
                            state_next = S_SH_UP_RD;
                        end
                    end
                    OP_REMOVE:
                    begin
                        if (idx_lt_n)
                        begin
                            state_next = S_SH_DN_RD;
                        end
                    end
                    OP_READ:
                    begin
                        if (idx_lt_n)
                        begin
                            state_next = S_READ_WAIT;
                        end
                    end
                    OP_CARDINAL:
                    begin
                        if (count_reg != '0)
                        begin
                            state_next = S_CA_RD0;
                        end
                    end
                    OP_EVAL_CUM, OP_EVAL_NRM:
                    begin
                        if (n16 >= 16'd2)
                        begin
                            state_next = S_MUL0;
                        end
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_SH_UP_RD:  state_next = (ptr_reg == ins_reg) ? S_INS_WR : S_SH_UP_WR;
            S_SH_UP_WR:  state_next = S_SH_UP_RD;
            S_INS_WR:    state_next = S_DONE;
            S_SH_DN_RD:
            begin
                state_next = (16'(ptr_reg) + 16'd1 >= n16) ? S_DONE : S_SH_DN_WR;
            end
            S_SH_DN_WR:  state_next = S_SH_DN_RD;
            S_READ_WAIT: state_next = S_DONE;
            S_CA_RD0:
            begin
                state_next = (16'(ptr_reg) + 16'd1 >= n16) ? S_CA_END : S_CA_RD1;
            end
            S_CA_RD1:    state_next = S_CA_DX;
            S_CA_DX:     state_next = S_MUL0;
            S_CA_DY:     state_next = S_MUL0;
            S_CA_WR:     state_next = S_CA_RD0;
            S_CA_END:    state_next = S_DONE;
            S_EV_SEG:    state_next = S_EV_RD1;
            S_EV_RD1:    state_next = S_MUL0;
            S_EV_T2:     state_next = S_MUL0;
            S_EV_T3:     state_next = S_EV_AX;
            S_EV_AX:     state_next = S_MUL0;
            S_EV_M1:     state_next = S_MUL0;
            S_EV_M2:     state_next = S_MUL0;
            S_EV_M3:     state_next = S_EV_FIN;
            S_EV_FIN:    state_next = axis_reg ? S_DONE : S_EV_AX;
            S_MUL0:      state_next = S_MUL1;
            S_MUL1:      state_next = ret_reg;
            S_DONE:      state_next = load_out ? S_IDLE : S_DONE;
            default:     state_next = S_IDLE;
        endcase
    end

    // ---------------------------------------------------------------- outputs
    always_comb
    begin
        pos_re  = 1'b0;
        vel_re  = 1'b0;
        pos_we  = 1'b0;
        vel_we  = 1'b0;
        rd_addr = '0;
        wr_addr = '0;
        pos_wd  = {py_reg, px_reg};
        vel_wd  = {vy_reg, vx_reg};
        s_axis_tready = (state_reg == S_IDLE);
        case (state_reg)
            S_DISPATCH:
            begin
                rd_addr = AW'(idx_reg);
                wr_addr = AW'(idx_reg);
                if (idx_lt_n)
                begin
                    pos_we = (op_reg == OP_SET_PT) || (op_reg == OP_SET_POS);
                    vel_we = (op_reg == OP_SET_PT) || (op_reg == OP_SET_VEL);
                    pos_re = (op_reg == OP_READ);
                    vel_re = (op_reg == OP_READ);
                end
                if ((op_reg == OP_CARDINAL) && (count_reg != '0))
                begin
                    wr_addr = '0;
                    vel_wd  = {start_y_reg, start_x_reg};
                    vel_we  = 1'b1;
                end
            end
            S_SH_UP_RD:
            begin
                rd_addr = AW'(ptr_reg - CW'(1));
                pos_re  = (ptr_reg != ins_reg);
                vel_re  = (ptr_reg != ins_reg);
            end
            S_SH_UP_WR, S_SH_DN_WR:
            begin
                wr_addr = AW'(ptr_reg);
                pos_wd  = pos_rd_reg;
                vel_wd  = vel_rd_reg;
                pos_we  = 1'b1;
                vel_we  = 1'b1;
            end
            S_INS_WR:
            begin
                wr_addr = AW'(ins_reg);
                pos_we  = 1'b1;
                vel_we  = 1'b1;
            end
            S_SH_DN_RD:
            begin
                rd_addr = AW'(ptr_reg + CW'(1));
                pos_re  = (16'(ptr_reg) + 16'd1 < n16);
                vel_re  = (16'(ptr_reg) + 16'd1 < n16);
            end
            S_CA_RD0:
            begin
                rd_addr = AW'(ptr_reg - CW'(1));
                pos_re  = (16'(ptr_reg) + 16'd1 < n16);
            end
            S_CA_RD1:
            begin
                rd_addr = AW'(ptr_reg + CW'(1));
                pos_re  = 1'b1;
            end
            S_CA_WR:
            begin
                wr_addr = AW'(ptr_reg);
                vel_wd  = {card_v, vnx_reg};
                vel_we  = 1'b1;
            end
            S_CA_END:
            begin
                wr_addr = AW'(count_reg - CW'(1));
                vel_wd  = {end_y_reg, end_x_reg};
                vel_we  = 1'b1;
            end
            S_EV_SEG:
            begin
                rd_addr = AW'(seg_c);
                pos_re  = 1'b1;
                vel_re  = 1'b1;
            end
            S_EV_RD1:
            begin
                rd_addr = seg_reg + AW'(1);
                pos_re  = 1'b1;
                vel_re  = 1'b1;
            end
            default:
            begin
                pos_re = 1'b0;
            end
        endcase
    end

    // ---------------------------------------------------------------- memories
    always_ff @(posedge clk)
    begin
        if (pos_we)
        begin
            pos_mem[wr_addr] <= pos_wd;
        end
        if (pos_re)
        begin
            pos_rd_reg <= pos_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (vel_we)
        begin
            vel_mem[wr_addr] <= vel_wd;
        end
        if (vel_re)
        begin
            vel_rd_reg <= vel_mem[rd_addr];
        end
    end

    // ---------------------------------------------------------------- control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ret_reg       <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            tension_reg   <= '0;
            start_x_reg   <= '0;
            start_y_reg   <= '0;
            end_x_reg     <= '0;
            end_y_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_TENSION: tension_reg <= cfg_data[17:0];
                    CFG_START_X: start_x_reg <= cfg_data;
                    CFG_START_Y: start_y_reg <= cfg_data;
                    CFG_END_X:   end_x_reg   <= cfg_data;
                    CFG_END_Y:   end_y_reg   <= cfg_data;
                    default:     tension_reg <= tension_reg;
                endcase
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_DISPATCH:
                begin
                    if (op_reg == OP_CLEAR)
                    begin
                        count_reg <= '0;
                    end
                    if ((op_reg == OP_EVAL_CUM) || (op_reg == OP_EVAL_NRM))
                    begin
                        ret_reg <= S_EV_SEG;
                    end
                end
                S_INS_WR:   count_reg <= count_reg + CW'(1);
                S_SH_DN_RD:
                begin
                    if (16'(ptr_reg) + 16'd1 >= n16)
                    begin
                        count_reg <= count_reg - CW'(1);
                    end
                end
                S_CA_DX:  ret_reg <= S_CA_DY;
                S_CA_DY:  ret_reg <= S_CA_WR;
                S_EV_RD1: ret_reg <= S_EV_T2;
                S_EV_T2:  ret_reg <= S_EV_T3;
                S_EV_AX:  ret_reg <= S_EV_M1;
                S_EV_M1:  ret_reg <= S_EV_M2;
                S_EV_M2:  ret_reg <= S_EV_M3;
                default:  ret_reg <= ret_reg;
            endcase
        end
    end

    // ---------------------------------------------------------------- datapath
    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            op_reg  <= s_axis_tdata[3:0];
            idx_reg <= s_axis_tdata[11:4];
            px_reg  <= s_axis_tdata[43:12];
            py_reg  <= s_axis_tdata[75:44];
            vx_reg  <= s_axis_tdata[107:76];
            vy_reg  <= s_axis_tdata[139:108];
            tp_reg  <= s_axis_tdata[163:140];
        end
        if (load_out)
        begin
            out_x_reg   <= res_x_reg;
            out_y_reg   <= res_y_reg;
            out_vx_reg  <= res_vx_reg;
            out_vy_reg  <= res_vy_reg;
            out_cnt_reg <= 9'(count_reg);
            out_st_reg  <= status_reg;
        end
        case (state_reg)
            S_DISPATCH:
            begin
                res_x_reg  <= '0;
                res_y_reg  <= '0;
                res_vx_reg <= '0;
                res_vy_reg <= '0;
                status_reg <= ST_OK;
                ptr_reg    <= count_reg;
                ins_reg    <= (op_reg == OP_APPEND) ? count_reg : CW'(idx_reg);
                case (op_reg)
                    OP_APPEND:
                    begin
                        if (is_full)
                        begin
                            status_reg <= ST_FULL;
                        end
                    end
                    OP_INSERT:
                    begin
                        if (!idx_le_n)
                        begin
                            status_reg <= ST_BAD_INDEX;
                        end
                        else if (is_full)
                        begin
                            status_reg <= ST_FULL;
                        end
                    end
                    OP_REMOVE, OP_SET_PT, OP_SET_POS, OP_SET_VEL, OP_READ:
                    begin
                        ptr_reg <= CW'(idx_reg);
                        if (!idx_lt_n)
                        begin
                            status_reg <= ST_BAD_INDEX;
                        end
                    end
                    OP_CARDINAL:
                    begin
                        ptr_reg <= CW'(1);
                        if (count_reg == '0)
                        begin
                            status_reg <= ST_TOO_FEW;
                        end
                    end
                    OP_EVAL_CUM, OP_EVAL_NRM:
                    begin
                        if (n16 < 16'd2)
                        begin
                            status_reg <= ST_TOO_FEW;
                        end
                        mul_a_reg   <= MUL_AW'(tp_reg);
                        mul_b_reg   <= (op_reg == OP_EVAL_NRM) ? MUL_BW'(count_reg - CW'(1))
                                                               : MUL_BW'(1);
                        mul_neg_reg <= 1'b0;
                    end
                    default:
                    begin
                        status_reg <= ST_OK;
                    end
                endcase
            end
            S_SH_UP_WR: ptr_reg <= ptr_reg - CW'(1);
            S_SH_DN_WR: ptr_reg <= ptr_reg + CW'(1);
            S_READ_WAIT:
            begin
                res_x_reg  <= pos_rd_reg[31:0];
                res_y_reg  <= pos_rd_reg[63:32];
                res_vx_reg <= vel_rd_reg[31:0];
                res_vy_reg <= vel_rd_reg[63:32];
            end
            S_CA_RD1:   pm_reg <= pos_rd_reg;
            S_CA_DX, S_CA_DY:
            begin
                if (state_reg == S_CA_DY)
                begin
                    vnx_reg <= card_v;
                end
                mul_a_reg   <= MUL_AW'(card_d_mag);
                mul_b_reg   <= MUL_BW'(scale_mag);
                mul_neg_reg <= card_d[32] ^ scale[XW-1];
            end
            S_CA_WR:    ptr_reg <= ptr_reg + CW'(1);
            S_EV_SEG:
            begin
                seg_reg <= AW'(seg_c);
                tl_reg  <= tl_c;
            end
            S_EV_RD1:
            begin
                p0_reg      <= pos_rd_reg;
                v0_reg      <= vel_rd_reg;
                axis_reg    <= 1'b0;
                mul_a_reg   <= MUL_AW'(tl_reg);
                mul_b_reg   <= MUL_BW'(tl_reg);
                mul_neg_reg <= 1'b0;
            end
            S_EV_T2:
            begin
                t2_reg      <= mul_rnd[48:16];
                mul_a_reg   <= MUL_AW'(mul_rnd[48:16]);
                mul_b_reg   <= MUL_BW'(tl_reg);
                mul_neg_reg <= 1'b0;
            end
            S_EV_T3:    t3_reg <= mul_rnd[56:16];
            S_EV_AX:
            begin
                c_reg       <= c_c;
                e_reg       <= e_c;
                acc_reg     <= 64'(p0a) <<< 16;
                mul_a_reg   <= MUL_AW'(tl_reg);
                mul_b_reg   <= v0_mag;
                mul_neg_reg <= v036[35];
            end
            S_EV_M1:
            begin
                acc_reg     <= acc_reg + mul_s;
                mul_a_reg   <= MUL_AW'(t2_reg);
                mul_b_reg   <= c_mag;
                mul_neg_reg <= c_reg[35];
            end
            S_EV_M2:
            begin
                acc_reg     <= acc_reg + mul_s;
                mul_a_reg   <= t3_reg;
                mul_b_reg   <= e_mag;
                mul_neg_reg <= e_reg[35];
            end
            S_EV_M3:    acc_reg <= acc_reg + mul_s;
            S_EV_FIN:
            begin
                axis_reg <= 1'b1;
                if (axis_reg)
                begin
                    res_y_reg <= ev_r;
                end
                else
                begin
                    res_x_reg <= ev_r;
                end
            end
            S_MUL0:     mul_acc_reg <= MUL_PW'(mul_part);
            S_MUL1:     mul_acc_reg <= mul_acc_reg + (MUL_PW'(mul_part) << MUL_CW);
            default:    axis_reg <= axis_reg;
        endcase
    end

    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'd0, out_st_reg, out_cnt_reg, out_vy_reg, out_vx_reg,
                            out_y_reg, out_x_reg};

endmodule
